@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mtwd_pkg.sv @@
`default_nettype none

package mtwd_pkg;

    // table size
    localparam int TASK_COUNT = 8;
    localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    // field widths
    localparam int FUNC_W  = 3;
    localparam int TASK_W  = 4;
    localparam int NOW_W   = 48;
    localparam int CNT_W   = 32;
    localparam int MS_W    = 39;
    localparam int SUB_W   = 10;
    localparam int TR_W    = 2;

    // time base
    localparam int unsigned US_PER_MS = 1000;
    localparam logic [NOW_W-1:0] NOW_MAX       = {NOW_W{1'b1}};
    localparam logic [NOW_W-1:0] TIMEOUT_RESET = NOW_W'(64'd5000 * 64'(US_PER_MS));
    localparam logic [SUB_W-1:0] SUB_LAST      = SUB_W'(US_PER_MS - 1);

    // stream packing
    localparam int IN_BITS     = TASK_W + 1;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 3 + TR_W + 2 * CNT_W + MS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_TICK       = 3'd0;
    localparam logic [FUNC_W-1:0] OP_REGISTER   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_UNREGISTER = 3'd2;
    localparam logic [FUNC_W-1:0] OP_FEED       = 3'd3;
    localparam logic [FUNC_W-1:0] OP_QUERY      = 3'd4;
    localparam logic [FUNC_W-1:0] OP_NOTE       = 3'd5;

    // health transition codes
    localparam logic [TR_W-1:0] TR_NONE      = 2'd0;
    localparam logic [TR_W-1:0] TR_TIMEOUT   = 2'd1;
    localparam logic [TR_W-1:0] TR_RECOVERED = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } mtwd_cmd_t;

endpackage

`default_nettype wire

@@ src/mtwd_ctrl.sv @@
`default_nettype none

module mtwd_ctrl
    import mtwd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output mtwd_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    // take a transaction while idle once the result slot is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign m_tvalid = m_valid_reg;

    // state sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/mtwd_datapath.sv @@
`default_nettype none

module mtwd_datapath
    import mtwd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire mtwd_cmd_t              cmd,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [FUNC_W-1:0]      s_tuser,
    input  wire logic                   cfg_wr_en,
    input  wire logic [NOW_W-1:0]       cfg_wr_data,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    // captured item
    logic [FUNC_W-1:0] func_reg;
    logic [TASK_W-1:0] task_reg;
    logic              obs_reg;

    // time base, kept in microseconds and split into ms plus remainder
    logic [NOW_W-1:0] now_us_reg;
    logic [MS_W-1:0]  now_ms_reg;
    logic [SUB_W-1:0] now_sub_reg;
    logic [NOW_W-1:0] timeout_reg;

    // task table
    logic             regd_reg    [TASK_COUNT];
    logic             known_reg   [TASK_COUNT];
    logic             lalive_reg  [TASK_COUNT];
    logic [NOW_W-1:0] feed_reg    [TASK_COUNT];
    logic [MS_W-1:0]  feed_ms_reg [TASK_COUNT];
    logic [CNT_W-1:0] tout_reg    [TASK_COUNT];
    logic [CNT_W-1:0] recov_reg   [TASK_COUNT];

    logic [OUT_TDATA_W-1:0] out_reg;

    logic [IDX_W-1:0] idx;
    logic             hit;
    logic             regd_nx, known_nx, lalive_nx;
    logic [NOW_W-1:0] feed_nx;
    logic [MS_W-1:0]  feed_ms_nx;
    logic [CNT_W-1:0] tout_nx, recov_nx;
    logic [TR_W-1:0]  tr_nx;
    logic [NOW_W-1:0] elapsed;
    logic             alive_nx;

    assign idx = task_reg[IDX_W-1:0];
    assign hit = ({1'b0, task_reg} < (TASK_W + 1)'(TASK_COUNT));

    // time base advance on a tick; item capture is in the next block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_us_reg  <= '0;
            now_ms_reg  <= '0;
            now_sub_reg <= '0;
        end else if (cmd.load && (s_tuser == OP_TICK)) begin
            if (now_us_reg == NOW_MAX) begin
                now_us_reg  <= '0;
                now_ms_reg  <= '0;
                now_sub_reg <= '0;
            end else begin
                now_us_reg <= now_us_reg + NOW_W'(1);
                if (now_sub_reg == SUB_LAST) begin
                    now_sub_reg <= '0;
                    now_ms_reg  <= now_ms_reg + MS_W'(1);
                end else begin
                    now_sub_reg <= now_sub_reg + SUB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_tuser;
            task_reg <= s_tdata[TASK_W-1:0];
            obs_reg  <= s_tdata[TASK_W];
        end
    end

    // timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // next entry contents for the addressed task
    always_comb begin
        regd_nx    = regd_reg[idx];
        known_nx   = known_reg[idx];
        lalive_nx  = lalive_reg[idx];
        feed_nx    = feed_reg[idx];
        feed_ms_nx = feed_ms_reg[idx];
        tout_nx    = tout_reg[idx];
        recov_nx   = recov_reg[idx];
        tr_nx      = TR_NONE;
        case (func_reg)
            OP_REGISTER: begin
                regd_nx    = 1'b1;
                feed_nx    = now_us_reg;
                feed_ms_nx = now_ms_reg;
                known_nx   = 1'b1;
                lalive_nx  = 1'b1;
            end
            OP_UNREGISTER: begin
                regd_nx   = 1'b0;
                known_nx  = 1'b0;
                lalive_nx = 1'b0;
            end
            OP_FEED: begin
                if (regd_reg[idx]) begin
                    feed_nx    = now_us_reg;
                    feed_ms_nx = now_ms_reg;
                end
            end
            OP_NOTE: begin
                if (regd_reg[idx]) begin
                    if (!known_reg[idx]) begin
                        known_nx  = 1'b1;
                        lalive_nx = obs_reg;
                    end else if (lalive_reg[idx] != obs_reg) begin
                        lalive_nx = obs_reg;
                        if (obs_reg) begin
                            recov_nx = recov_reg[idx] + CNT_W'(1);
                            tr_nx    = TR_RECOVERED;
                        end else begin
                            tout_nx = tout_reg[idx] + CNT_W'(1);
                            tr_nx   = TR_TIMEOUT;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // liveness from elapsed time, wrapping at the counter width
    assign elapsed  = now_us_reg - feed_nx;
    assign alive_nx = regd_nx && (elapsed < timeout_reg);

    // table write back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_COUNT; i++) begin
                regd_reg[i]    <= 1'b0;
                known_reg[i]   <= 1'b0;
                lalive_reg[i]  <= 1'b0;
                feed_reg[i]    <= '0;
                feed_ms_reg[i] <= '0;
                tout_reg[i]    <= '0;
                recov_reg[i]   <= '0;
            end
        end else if (cmd.exec && hit) begin
            regd_reg[idx]    <= regd_nx;
            known_reg[idx]   <= known_nx;
            lalive_reg[idx]  <= lalive_nx;
            feed_reg[idx]    <= feed_nx;
            feed_ms_reg[idx] <= feed_ms_nx;
            tout_reg[idx]    <= tout_nx;
            recov_reg[idx]   <= recov_nx;
        end
    end

    // result register, all zero for an out of range task
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (hit) begin
                out_reg <= OUT_TDATA_W'({feed_ms_nx, recov_nx, tout_nx, tr_nx,
                                         alive_nx, regd_nx, 1'b1});
            end else begin
                out_reg <= '0;
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

@@ src/multi_task_watchdog_table.sv @@
// an accepted transaction is captured, and its result is registered in the table update state that follows
// items are handled one at a time (capture, then table update); no new item is accepted during the update
// a new item is taken while the previous result is being taken on the same edge
// reset: synchronous active-low aresetn clears the time base, the task table,
//   the result valid flag and loads the timeout with its default; no clearing pass
`default_nettype none

`include "assert_macros.svh"

module multi_task_watchdog_table
    import mtwd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // fields: task_req [3:0], observed_alive [4], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // fields: func [2:0]
    input  wire logic [FUNC_W-1:0]      s_tuser,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // fields: task_valid [0], registered [1], alive [2], transition [4:3],
    // timeout total [36:5], recovery total [68:37], last feed in ms [107:69], zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_wr_en,
    input  wire logic [NOW_W-1:0]       cfg_wr_data
);

    mtwd_cmd_t cmd;

    // sequencing and result handshake
    mtwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // time base, task table and result register
    mtwd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata)
    );

    // checks
    `ASSERT_IMPLY(a_accept_slot_free, aclk, aresetn, cmd.load, (!m_tvalid || m_tready), "transaction accepted while result slot is held")
    `ASSERT_NEXT(a_exec_gives_result, aclk, aresetn, cmd.exec, m_tvalid, "table update did not present a result")
    `ASSERT_IMPLY(a_invalid_task_zero, aclk, aresetn, (m_tvalid && !m_tdata[0]), (m_tdata[OUT_BITS-1:1] == '0), "out of range task gave a nonzero result")
    `ASSERT_IMPLY(a_alive_needs_reg, aclk, aresetn, (m_tvalid && m_tdata[2]), m_tdata[1], "alive reported for an unregistered task")

endmodule

`default_nettype wire
